[hdl/mbps_pkg.sv]
// Types and constants shared by the masked byte pattern search block.
// Used by mbps_cell and masked_byte_pattern_search_top; no dependencies.
package mbps_pkg;

    localparam int REG_PATTERN_BYTES = 16;
    localparam int LEN_W             = 5;
    localparam int COUNT_W           = 16;
    localparam int ADDR_W            = 64;
    localparam int CFG_IDX_W         = 3;

    typedef logic [7:0]           t_byte;
    typedef logic [COUNT_W-1:0]   t_count;
    typedef logic [LEN_W-1:0]     t_len;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_count COUNT_MAX = '1;

    // configuration register indexes
    localparam t_cfg_idx CFG_PAT_LOW  = 3'd0;
    localparam t_cfg_idx CFG_PAT_HIGH = 3'd1;
    localparam t_cfg_idx CFG_MASK     = 3'd2;
    localparam t_cfg_idx CFG_LENGTH   = 3'd3;
    localparam t_cfg_idx CFG_LIMIT    = 3'd4;
    localparam t_cfg_idx CFG_BASE     = 3'd5;

    typedef struct packed {
        t_byte data_byte;
        logic  region_end;
    } t_in_beat;

    typedef struct packed {
        logic [ADDR_W-1:0] match_address;
        logic              is_match;
        logic              end_of_region;
        t_count            matches_found;
    } t_out_beat;

endpackage

[hdl/mbps_cell.sv]
// One window cell: holds a byte, passes it to the next older cell on each shift.
// Depends on mbps_pkg.
module mbps_cell
    import mbps_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_shift,
    input  logic  i_clear,
    input  t_byte i_byte,
    input  t_byte i_expect,
    input  logic  i_care,
    output t_byte o_byte,
    output logic  o_hit
);

    t_byte r_byte;

    // compare the byte this cell takes on the shift, so the match sees the new window
    assign o_hit  = !i_care || (i_byte == i_expect);
    assign o_byte = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else if (i_shift) begin
            r_byte <= i_clear ? t_byte'(0) : i_byte;
        end
    end

endmodule

[hdl/masked_byte_pattern_search_top.sv]
// Top level of the masked byte pattern search block: config registers, window
// chain of mbps_cell, match and address pipeline. Depends on mbps_pkg, mbps_cell.
//
// Usage
//   Input channel (i_in_valid / o_in_stall / i_in_data): one region byte per beat,
//   in address order, region_end set on the final byte of a region.
//   Output channel (o_out_valid / i_out_stall / o_out_data): one beat for each
//   reported match and one for every final byte (both in one beat if they coincide).
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data): always
//   ready; write only while no accepted byte is still in the pipeline.
// Pipeline
//   A taken byte has its window compare registered into r_s1_match at the edge that
//   takes it; the limit check, count update and address add happen when that entry
//   leaves the r_s1 registers, as the result beat loads the output register.
//   Throughput one byte per cycle while the input is not stalled.
// Reset and stall
//   Synchronous reset clears every config register, the window, the byte and
//   match counters and both pipeline valids. While the receiver stalls, the held
//   beat stays put; bytes that give no result keep flowing, and the input stalls
//   only once a result beat is waiting behind the held one.
module masked_byte_pattern_search_top
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = 16,
    parameter int OFFSET_BITS       = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // byte stream in
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_beat             i_in_data,
    // result stream out
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_beat            o_out_data,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  t_cfg_idx             i_cfg_index,
    input  logic [ADDR_W-1:0]    i_cfg_data
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [63:0]            r_pat_low;
    logic [63:0]            r_pat_high;
    logic [REG_PATTERN_BYTES-1:0] r_mask;
    t_len                   r_len;
    t_count                 r_limit;
    logic [ADDR_W-1:0]      r_base;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_mask     <= '0;
            r_len      <= '0;
            r_limit    <= '0;
            r_base     <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PAT_LOW:  r_pat_low  <= i_cfg_data;
                CFG_PAT_HIGH: r_pat_high <= i_cfg_data;
                CFG_MASK:     r_mask     <= i_cfg_data[REG_PATTERN_BYTES-1:0];
                CFG_LENGTH:   r_len      <= i_cfg_data[LEN_W-1:0];
                CFG_LIMIT:    r_limit    <= i_cfg_data[COUNT_W-1:0];
                CFG_BASE:     r_base     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Handshake and pipeline control
    // ---------------------------------------------------------------
    logic                   r_s1_valid;
    logic                   r_s1_match;
    logic                   r_s1_last;
    logic [OFFSET_BITS-1:0] r_s1_off;
    logic                   r_out_valid;
    t_out_beat              r_out;

    logic in_take;
    logic out_free;
    logic s1_report;
    logic s1_emits;
    logic s1_go;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_go      = r_s1_valid && (!s1_emits || out_free);
    assign o_in_stall = r_s1_valid && !s1_go;
    assign in_take    = i_in_valid && !o_in_stall;

    // ---------------------------------------------------------------
    // Window chain: cell 0 holds the newest byte
    // ---------------------------------------------------------------
    logic [127:0] pat_all;
    t_byte        w_link   [MAX_PATTERN_BYTES];
    t_byte        w_expect [MAX_PATTERN_BYTES];
    logic [MAX_PATTERN_BYTES-1:0] w_care;
    logic [MAX_PATTERN_BYTES-1:0] w_hit;

    assign pat_all = {r_pat_high, r_pat_low};

    // align the pattern to window ages: age a faces pattern byte len-1-a
    always_comb begin
        for (int a = 0; a < MAX_PATTERN_BYTES; a++) begin
            w_expect[a] = '0;
            w_care[a]   = 1'b0;
            for (int i = 0; i < REG_PATTERN_BYTES; i++) begin
                if (int'(r_len) == i + a + 1) begin
                    w_expect[a] = pat_all[8*i +: 8];
                    w_care[a]   = r_mask[i];
                end
            end
        end
    end

    for (genvar a = 0; a < MAX_PATTERN_BYTES; a++) begin : g_cell
        t_byte cell_in;
        if (a == 0) begin : g_head
            assign cell_in = i_in_data.data_byte;
        end else begin : g_link
            assign cell_in = w_link[a-1];
        end
        mbps_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_shift  (in_take),
            .i_clear  (i_in_data.region_end),
            .i_byte   (cell_in),
            .i_expect (w_expect[a]),
            .i_care   (w_care[a]),
            .o_byte   (w_link[a]),
            .o_hit    (w_hit[a])
        );
    end

    // ---------------------------------------------------------------
    // Stage 1: byte counter, window match, start offset
    // ---------------------------------------------------------------
    logic [OFFSET_BITS-1:0] r_seen;
    logic [OFFSET_BITS-1:0] n_seen;
    logic [OFFSET_BITS-1:0] len_ext;
    logic                   seen_sat;
    logic                   len_ok;
    logic                   win_match;

    assign seen_sat = &r_seen;
    assign n_seen   = seen_sat ? r_seen : r_seen + 1'b1;
    assign len_ext  = OFFSET_BITS'(r_len);
    assign len_ok   = (r_len != '0) && (int'(r_len) <= REG_PATTERN_BYTES)
                    && (int'(r_len) <= MAX_PATTERN_BYTES);
    // once saturated the address would be wrong, so drop the match
    assign win_match = len_ok && !seen_sat && (n_seen >= len_ext) && (&w_hit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_seen <= i_in_data.region_end ? '0 : n_seen;
            end
            if (in_take) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_match <= win_match;
            r_s1_last  <= i_in_data.region_end;
            r_s1_off   <= n_seen - len_ext;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: limit check, match count, address, output register
    // ---------------------------------------------------------------
    t_count r_count;
    t_count n_count;

    assign s1_report = r_s1_match && ((r_limit == '0) || (r_count < r_limit));
    assign s1_emits  = s1_report || r_s1_last;
    assign n_count   = (s1_report && (r_count != COUNT_MAX)) ? r_count + 1'b1 : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_go) begin
                r_count <= r_s1_last ? '0 : n_count;
            end
            if (s1_go && s1_emits) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && s1_emits) begin
            r_out.match_address <= s1_report ? r_base + ADDR_W'(r_s1_off) : '0;
            r_out.is_match      <= s1_report;
            r_out.end_of_region <= r_s1_last;
            r_out.matches_found <= n_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // every result beat carries a match, a region end, or both
    a_beat_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.is_match || r_out.end_of_region))
        else $error("result beat with neither match nor region end");

    // a reported match has been counted
    a_match_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.is_match) |-> (r_out.matches_found != '0))
        else $error("match reported with zero count");

    // the address is zero whenever no match is reported
    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.is_match) |-> (r_out.match_address == '0))
        else $error("non-zero address without a match");

    // the final byte of a region restarts the byte counter
    a_seen_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && i_in_data.region_end) |=> (r_seen == '0))
        else $error("byte counter not cleared after region end");

endmodule
